// File: src/running_average_background_subtraction_assert.svh
// Assertion macros for the running-average background subtraction checker.
// Included by the checker file only; no other dependencies.
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACTION_ASSERT_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACTION_ASSERT_SVH

// ante in one cycle implies cons in the next, ignored while reset is high
`define RABS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rabs checker: property failed");

// cons must hold in the cycle after reset was seen high
`define RABS_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("rabs checker: wrong state after reset");

`endif

// File: src/rabs_pkg.sv
// Shared widths, register indexes and reset values for the background
// subtraction block. No dependencies.
`timescale 1ns / 1ps

package rabs_pkg;

   localparam int ADDR_BITS      = 19;
   localparam int PIXEL_BITS     = 8;
   localparam int ALPHA_BITS     = 9;
   localparam int FRAME_BITS     = 20;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 20;
   localparam int FRAC_BITS      = 8;
   localparam int PROD_BITS      = ALPHA_BITS + PIXEL_BITS;
   localparam int POS_CMP_BITS   = (ADDR_BITS + 1 > FRAME_BITS) ? ADDR_BITS + 1 : FRAME_BITS;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = ALPHA_BITS'(1 << FRAC_BITS);
   localparam logic [PROD_BITS-1:0]  BLEND_ROUND = PROD_BITS'(1 << (FRAC_BITS - 1));
   localparam logic [PIXEL_BITS-1:0] GHOST_MAX   = PIXEL_BITS'(255);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIFF_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLEND_WEIGHT   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELECTIVE_MODE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GHOST_LIMIT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_PIXELS   = 3'd4;

   localparam logic [PIXEL_BITS-1:0] DIFF_THRESHOLD_RESET = 8'd30;
   localparam logic [ALPHA_BITS-1:0] BLEND_WEIGHT_RESET   = 9'd13;
   localparam logic                  SELECTIVE_MODE_RESET = 1'b0;
   localparam logic [PIXEL_BITS-1:0] GHOST_LIMIT_RESET    = 8'd50;
   localparam logic [FRAME_BITS-1:0] FRAME_PIXELS_RESET   = 20'd307200;

endpackage

// File: src/rabs_if.sv
// Valid/ready channel interfaces: pixel requests and segmentation responses.
// Depends on rabs_pkg for field widths.
`timescale 1ns / 1ps

interface rabs_req_if;
   import rabs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel;
   logic                  load;

   modport source (output valid, output pixel, output load, input ready);
   modport sink   (input valid, input pixel, input load, output ready);
endinterface

interface rabs_rsp_if;
   import rabs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  foreground;
   logic [PIXEL_BITS-1:0] difference;
   logic                  end_of_frame;

   modport source (output valid, output foreground, output difference,
                   output end_of_frame, input ready);
   modport sink   (input valid, input foreground, input difference,
                   input end_of_frame, output ready);
endinterface

// File: src/running_average_background_subtraction.sv
// Running-average background subtraction with selective update and ghost
// suppression. Depends on rabs_pkg and the channel interfaces in rabs_if.sv.
//
//   channel    dir   fields                                   handshake
//   req_chan   in    pixel[7:0], load                          valid/ready
//   rsp_chan   out   foreground, difference[7:0], end_of_frame valid/ready
//   csr_*      in    csr_index[2:0], csr_wdata[19:0]           csr_we
//
// Three register stages: store read, difference and blend products, blend
// sum with store write and output register. One transaction per cycle while
// rsp_chan is ready, for frames of three pixels or more; with smaller frames
// the read-after-write interlock on the pixel stores holds req ready low
// until the earlier update to the same address is written. Synchronous reset
// clears the position and valid bits and resets the CSRs; the stores are not
// cleared. An output stall holds each stage only where it is full.
`timescale 1ns / 1ps

module running_average_background_subtraction (
   input  logic                                 clock,
   input  logic                                 reset,
   rabs_req_if.sink                             req_chan,
   rabs_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [rabs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rabs_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rabs_pkg::*;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  load;
      logic                  eof;
      logic [ADDR_BITS-1:0]  addr;
   } s1_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [ADDR_BITS-1:0]  addr;
      logic                  eof;
      logic                  fg;
      logic [PIXEL_BITS-1:0] diff;
      logic [PROD_BITS-1:0]  prod_pix;
      logic [PROD_BITS-1:0]  prod_bg;
      logic                  use_blend;
      logic                  bg_we;
      logic                  gc_we;
      logic [PIXEL_BITS-1:0] gc_val;
   } s2_type;

   typedef struct packed {
      logic                  fg;
      logic [PIXEL_BITS-1:0] diff;
      logic                  eof;
   } s3_type;

   // configuration
   logic [PIXEL_BITS-1:0] diff_threshold_ff, diff_threshold_in;
   logic [ALPHA_BITS-1:0] blend_weight_ff, blend_weight_in;
   logic                  selective_mode_ff, selective_mode_in;
   logic [PIXEL_BITS-1:0] ghost_limit_ff, ghost_limit_in;
   logic [FRAME_BITS-1:0] frame_pixels_ff, frame_pixels_in;

   // pixel stores
   logic [PIXEL_BITS-1:0] bg_mem [2**ADDR_BITS];
   logic [PIXEL_BITS-1:0] gc_mem [2**ADDR_BITS];
   logic [PIXEL_BITS-1:0] bg_rd_ff;
   logic [PIXEL_BITS-1:0] gc_rd_ff;

   // position and pipeline
   logic [ADDR_BITS-1:0] pos_ff, pos_in;
   logic [ADDR_BITS:0]   pos_inc;
   logic                 frame_end;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s3_valid_ff, s3_valid_in;
   s1_type               s1_ff, s1_in;
   s2_type               s2_ff, s2_in;
   s3_type               s3_ff, s3_in;
   logic                 adv1, adv2, adv3;
   logic                 hazard;
   logic                 accept;
   logic                 s1_move, s2_move;

   // stage 2 datapath
   logic [ALPHA_BITS-1:0] alpha;
   logic [PIXEL_BITS-1:0] diff_raw;
   logic                  fg_raw;
   logic [PIXEL_BITS-1:0] cnt_inc;
   logic                  ghost_over;

   // stage 3 datapath
   logic [PROD_BITS-1:0]  blend_sum;
   logic [PIXEL_BITS-1:0] bg_new;

   // ---------------- configuration ----------------
   always_comb begin
      diff_threshold_in = diff_threshold_ff;
      blend_weight_in   = blend_weight_ff;
      selective_mode_in = selective_mode_ff;
      ghost_limit_in    = ghost_limit_ff;
      frame_pixels_in   = frame_pixels_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DIFF_THRESHOLD: diff_threshold_in = csr_wdata[PIXEL_BITS-1:0];
            CSR_BLEND_WEIGHT:   blend_weight_in   = csr_wdata[ALPHA_BITS-1:0];
            CSR_SELECTIVE_MODE: selective_mode_in = csr_wdata[0];
            CSR_GHOST_LIMIT:    ghost_limit_in    = csr_wdata[PIXEL_BITS-1:0];
            CSR_FRAME_PIXELS:   frame_pixels_in   = csr_wdata[FRAME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_threshold_ff <= DIFF_THRESHOLD_RESET;
         blend_weight_ff   <= BLEND_WEIGHT_RESET;
         selective_mode_ff <= SELECTIVE_MODE_RESET;
         ghost_limit_ff    <= GHOST_LIMIT_RESET;
         frame_pixels_ff   <= FRAME_PIXELS_RESET;
      end else begin
         diff_threshold_ff <= diff_threshold_in;
         blend_weight_ff   <= blend_weight_in;
         selective_mode_ff <= selective_mode_in;
         ghost_limit_ff    <= ghost_limit_in;
         frame_pixels_ff   <= frame_pixels_in;
      end
   end

   // ---------------- handshake and flow ----------------
   assign adv3 = !s3_valid_ff || rsp_chan.ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   // an update to this address still in flight: its store write is not done
   assign hazard = (s1_valid_ff && (s1_ff.addr == pos_ff)) ||
                   (s2_valid_ff && (s2_ff.addr == pos_ff));

   assign req_chan.ready = adv1 && !hazard;
   assign accept         = req_chan.valid && req_chan.ready;
   assign s1_move        = adv2 && s1_valid_ff;
   assign s2_move        = adv3 && s2_valid_ff;

   assign pos_inc   = {1'b0, pos_ff} + {{ADDR_BITS{1'b0}}, 1'b1};
   assign frame_end = (POS_CMP_BITS'(pos_inc) >= POS_CMP_BITS'(frame_pixels_ff)) ||
                      pos_inc[ADDR_BITS];

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = frame_end ? '0 : pos_inc[ADDR_BITS-1:0];
      end
      s1_valid_in = adv1 ? accept : s1_valid_ff;
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // ---------------- stage 1: store read ----------------
   always_comb begin
      s1_in.pixel = req_chan.pixel;
      s1_in.load  = req_chan.load;
      s1_in.eof   = frame_end;
      s1_in.addr  = pos_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move && s2_ff.bg_we) begin
         bg_mem[s2_ff.addr] <= bg_new;
      end
      if (accept) begin
         bg_rd_ff <= bg_mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move && s2_ff.gc_we) begin
         gc_mem[s2_ff.addr] <= s2_ff.gc_val;
      end
      if (accept) begin
         gc_rd_ff <= gc_mem[pos_ff];
      end
   end

   // ---------------- stage 2: difference, decision, products ----------------
   always_comb begin
      alpha      = (blend_weight_ff > ALPHA_ONE) ? ALPHA_ONE : blend_weight_ff;
      diff_raw   = (s1_ff.pixel >= bg_rd_ff) ? (s1_ff.pixel - bg_rd_ff)
                                             : (bg_rd_ff - s1_ff.pixel);
      fg_raw     = diff_raw > diff_threshold_ff;
      cnt_inc    = (gc_rd_ff == GHOST_MAX) ? GHOST_MAX : gc_rd_ff + PIXEL_BITS'(1);
      ghost_over = cnt_inc > ghost_limit_ff;

      s2_in.pixel    = s1_ff.pixel;
      s2_in.addr     = s1_ff.addr;
      s2_in.eof      = s1_ff.eof;
      s2_in.fg       = s1_ff.load ? 1'b0 : fg_raw;
      s2_in.diff     = s1_ff.load ? '0 : diff_raw;
      s2_in.prod_pix = PROD_BITS'(alpha) * PROD_BITS'(s1_ff.pixel);
      s2_in.prod_bg  = PROD_BITS'(ALPHA_ONE - alpha) * PROD_BITS'(bg_rd_ff);

      priority if (s1_ff.load) begin
         s2_in.use_blend = 1'b0;
         s2_in.bg_we     = 1'b1;
         s2_in.gc_we     = 1'b1;
         s2_in.gc_val    = '0;
      end else if (!selective_mode_ff) begin
         s2_in.use_blend = 1'b1;
         s2_in.bg_we     = 1'b1;
         s2_in.gc_we     = 1'b0;
         s2_in.gc_val    = cnt_inc;
      end else if (!fg_raw) begin
         s2_in.use_blend = 1'b1;
         s2_in.bg_we     = 1'b1;
         s2_in.gc_we     = 1'b1;
         s2_in.gc_val    = '0;
      end else begin
         // foreground: a run past the ghost limit makes the pixel the background
         s2_in.use_blend = 1'b0;
         s2_in.bg_we     = ghost_over;
         s2_in.gc_we     = 1'b1;
         s2_in.gc_val    = cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------- stage 3: blend, store write, output ----------------
   always_comb begin
      blend_sum = s2_ff.prod_pix + s2_ff.prod_bg + BLEND_ROUND;
      bg_new    = s2_ff.use_blend ? blend_sum[FRAC_BITS +: PIXEL_BITS] : s2_ff.pixel;
      s3_in.fg   = s2_ff.fg;
      s3_in.diff = s2_ff.diff;
      s3_in.eof  = s2_ff.eof;
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         s3_ff <= s3_in;
      end
   end

   assign rsp_chan.valid        = s3_valid_ff;
   assign rsp_chan.foreground   = s3_ff.fg;
   assign rsp_chan.difference   = s3_ff.diff;
   assign rsp_chan.end_of_frame = s3_ff.eof;

endmodule

// File: src/rabs_checker.sv
// Port-level checker for the background subtraction block, bound to its top.
// Depends on rabs_pkg and running_average_background_subtraction_assert.svh.
`timescale 1ns / 1ps
`include "running_average_background_subtraction_assert.svh"

module rabs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_foreground,
   input logic [rabs_pkg::PIXEL_BITS-1:0] rsp_difference,
   input logic                            rsp_end_of_frame
);

   logic [rabs_pkg::PIXEL_BITS+1:0] rsp_payload;

   assign rsp_payload = {rsp_foreground, rsp_difference, rsp_end_of_frame};

   // a stalled response transaction stays offered and unchanged
   `RABS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RABS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))

   // reset empties the pipeline: nothing offered, input side open
   `RABS_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_valid)
   `RABS_ASSERT_AFTER_RESET(a_reset_ready, clock, reset, req_ready)

endmodule

bind running_average_background_subtraction rabs_checker u_rabs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_foreground   (rsp_chan.foreground),
   .rsp_difference   (rsp_chan.difference),
   .rsp_end_of_frame (rsp_chan.end_of_frame)
);

// File: tb/sv/running_average_background_subtraction_test.sv
// Self-checking regression for the running-average background subtraction
// block: a scoreboard class predicts every segmentation result, plain tasks
// drive pixels and registers. Depends on rabs_pkg, rabs_if.sv and the RTL.
`timescale 1ns / 1ps

module running_average_background_subtraction_test;
   import rabs_pkg::*;

   localparam int unsigned STORE_MASK   = (1 << ADDR_BITS) - 1;
   localparam int          MAX_REPORTS  = 10;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          HOLD_CYCLES  = 300;

   typedef struct packed {
      logic                  fg;
      logic [PIXEL_BITS-1:0] diff;
      logic                  eof;
   } segment_type;

   class bg_subtract_scoreboard_type;
      bit [PIXEL_BITS-1:0] bg_mem    [0:STORE_MASK];
      bit [PIXEL_BITS-1:0] ghost_mem [0:STORE_MASK];
      int unsigned pos;
      int unsigned threshold, alpha, selective, ghost_lim, frame_len;
      segment_type expected_segments[$];
      int          mismatch_count;

      function new();
         pos            = 0;
         threshold      = 32'(DIFF_THRESHOLD_RESET);
         alpha          = 32'(BLEND_WEIGHT_RESET);
         selective      = 32'(SELECTIVE_MODE_RESET);
         ghost_lim      = 32'(GHOST_LIMIT_RESET);
         frame_len      = 32'(FRAME_PIXELS_RESET);
         mismatch_count = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_DIFF_THRESHOLD: threshold = 32'(val[PIXEL_BITS-1:0]);
            CSR_BLEND_WEIGHT:   alpha     = 32'(val[ALPHA_BITS-1:0]);
            CSR_SELECTIVE_MODE: selective = 32'(val[0]);
            CSR_GHOST_LIMIT:    ghost_lim = 32'(val[PIXEL_BITS-1:0]);
            CSR_FRAME_PIXELS:   frame_len = 32'(val[FRAME_BITS-1:0]);
            default: ;
         endcase
      endfunction

      function bit [PIXEL_BITS-1:0] blended(int unsigned pix, int unsigned bg);
         int unsigned a;
         // weights above one saturate
         a = (alpha > 32'(ALPHA_ONE)) ? 32'(ALPHA_ONE) : alpha;
         return PIXEL_BITS'((a * pix + (32'(ALPHA_ONE) - a) * bg + 32'(BLEND_ROUND))
                            >> FRAC_BITS);
      endfunction

      function void note_pixel(logic [PIXEL_BITS-1:0] pix, logic ld);
         int unsigned bg, cnt, nxt, p;
         segment_type r;
         r = '0;
         p = 32'(pix);
         if (ld) begin
            bg_mem[pos]    = pix;
            ghost_mem[pos] = '0;
         end else begin
            bg     = 32'(bg_mem[pos]);
            r.diff = PIXEL_BITS'((p >= bg) ? p - bg : bg - p);
            r.fg   = (32'(r.diff) > threshold);
            if (selective == 0) begin
               bg_mem[pos] = blended(p, bg);
            end else if (!r.fg) begin
               bg_mem[pos]    = blended(p, bg);
               ghost_mem[pos] = '0;
            end else begin
               cnt = 32'(ghost_mem[pos]);
               if (cnt < 32'(GHOST_MAX)) cnt++;
               ghost_mem[pos] = PIXEL_BITS'(cnt);
               // long foreground run: take the pixel as the new background
               if (cnt > ghost_lim) bg_mem[pos] = pix;
            end
         end
         nxt = (pos + 1) & STORE_MASK;
         if (pos + 1 >= frame_len || nxt == 0) begin
            r.eof = 1'b1;
            nxt   = 0;
         end
         pos = nxt;
         expected_segments.push_back(r);
      endfunction

      function void check_segment(segment_type got);
         segment_type want;
         if (expected_segments.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result with no transaction pending: fg=%0b diff=%0d eof=%0b",
                        $time, got.fg, got.diff, got.eof);
            return;
         end
         want = expected_segments.pop_front();
         if (got.fg !== want.fg || got.diff !== want.diff || got.eof !== want.eof) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: expected fg=%0b diff=%0d eof=%0b, got fg=%0b diff=%0d eof=%0b",
                        $time, want.fg, want.diff, want.eof, got.fg, got.diff, got.eof);
         end
      endfunction

      function int pending();
         return expected_segments.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   rabs_req_if req();
   rabs_rsp_if rsp();

   running_average_background_subtraction dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bg_subtract_scoreboard_type sb;

   // stimulus-side view of the stores: which entries hold a background
   bit                  loaded [0:STORE_MASK];
   bit [PIXEL_BITS-1:0] scene  [0:STORE_MASK];
   int unsigned         gen_pos, gen_frame;
   int unsigned         send_idle_pct, recv_idle_pct;
   int                  hold_left;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      segment_type seen;
      if (!reset) begin
         if (req.valid && req.ready) sb.note_pixel(req.pixel, req.load);
         if (rsp.valid && rsp.ready) begin
            seen = {rsp.foreground, rsp.difference, rsp.end_of_frame};
            sb.check_segment(seen);
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input logic ld);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.pixel <= pix;
      req.load  <= ld;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   // a pixel at a never-loaded position is always turned into a load
   task automatic issue(input logic [PIXEL_BITS-1:0] pix, input logic ld);
      int unsigned nxt;
      if (!loaded[gen_pos]) ld = 1'b1;
      loaded[gen_pos] = 1'b1;
      scene[gen_pos]  = pix;
      nxt = (gen_pos + 1) & STORE_MASK;
      if (gen_pos + 1 >= gen_frame || nxt == 0) nxt = 0;
      gen_pos = nxt;
      send_pixel(pix, ld);
   endtask

   task automatic issue_random();
      int pick, p;
      pick = $urandom_range(99);
      if (pick < 45) begin
         // small drift around what this position last saw
         p = int'(scene[gen_pos]) + int'($urandom_range(24)) - 12;
         if (p < 0) p = 0;
         if (p > 255) p = 255;
      end else if (pick < 75) begin
         p = $urandom_range(255);
      end else begin
         p = $urandom_range(1) * 255;
      end
      issue(PIXEL_BITS'(p), $urandom_range(99) < 8);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(val);
      sb.set_reg(idx, CSR_DATA_BITS'(val));
      if (idx == CSR_FRAME_PIXELS) gen_frame = val & ((1 << FRAME_BITS) - 1);
      @(negedge clock);
   endtask

   task automatic configure(input int unsigned thr, input int unsigned alpha,
                            input int unsigned sel, input int unsigned glim,
                            input int unsigned frame);
      put_reg(CSR_DIFF_THRESHOLD, thr);
      put_reg(CSR_BLEND_WEIGHT, alpha);
      put_reg(CSR_SELECTIVE_MODE, sel);
      put_reg(CSR_GHOST_LIMIT, glim);
      put_reg(CSR_FRAME_PIXELS, frame);
      csr_we <= 1'b0;
   endtask

   task automatic configure_random();
      int unsigned thr, alpha, sel, glim, frame, r;
      r   = $urandom_range(9);
      thr = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(40);
      r   = $urandom_range(5);
      alpha = (r == 0) ? 0 : (r == 1) ? 256 : (r == 2) ? $urandom_range(511, 257)
            : $urandom_range(256);
      sel  = $urandom_range(1);
      r    = $urandom_range(7);
      glim = (r == 0) ? 255 : (r == 1) ? $urandom_range(255) : $urandom_range(6);
      r    = $urandom_range(19);
      frame = (r == 0) ? 0 : (r == 1) ? $urandom_range(300, 17)
            : (r == 2) ? (1 << ADDR_BITS) : $urandom_range(16, 1);
      configure(thr, alpha, sel, glim, frame);
   endtask

   task automatic settle();
      req.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      #20_000_000;
      $display("running_average_background_subtraction regression: fail");
      $finish;
   end

   initial begin
      int n;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.pixel = '0;
      req.load  = 1'b0;
      rsp.ready = 1'b0;
      sb        = new();
      gen_pos   = 0;
      gen_frame = 32'(FRAME_PIXELS_RESET);
      hold_left = 0;
      send_idle_pct = 35;
      recv_idle_pct = 69;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register reset values, the first pixels are all loads
      issue(8'd0, 1'b1);
      issue(8'd255, 1'b1);
      issue(8'd128, 1'b1);
      issue(8'd1, 1'b1);
      settle();
      put_reg(CSR_FRAME_PIXELS, 4);
      csr_we <= 1'b0;
      issue(8'd7, 1'b1);
      issue(8'd255, 1'b0);   // full-scale difference
      issue(8'd0, 1'b0);
      issue(8'd128, 1'b0);   // no difference
      issue(8'd31, 1'b0);    // difference equal to the threshold
      settle();

      // zero frame size: every pixel ends a frame
      configure(0, 0, 0, 0, 0);
      issue(8'd200, 1'b0);
      issue(8'd200, 1'b0);
      settle();

      configure(255, 256, 0, 255, 1 << ADDR_BITS);
      issue(8'd0, 1'b0);
      issue(8'd255, 1'b0);
      issue(8'd9, 1'b0);
      settle();

      // selective update, weight above one, immediate ghost replacement
      configure(10, 511, 1, 0, 2);
      issue(8'd100, 1'b0);
      issue(8'd40, 1'b0);
      issue(8'd41, 1'b0);
      issue(8'd40, 1'b0);
      issue(8'd255, 1'b1);
      issue(8'd250, 1'b0);
      settle();

      // ghost counter runs into saturation, then a lower limit replaces
      configure(0, 128, 1, 255, 1);
      issue(8'd0, 1'b1);
      issue(8'd0, 1'b1);
      repeat (257) issue(8'd255, 1'b0);
      settle();
      put_reg(CSR_GHOST_LIMIT, 254);
      csr_we <= 1'b0;
      issue(8'd255, 1'b0);
      issue(8'd255, 1'b0);
      settle();

      for (int ph = 0; ph < 24; ph++) begin
         if (ph == 8) begin
            send_idle_pct = 69;
            recv_idle_pct = 35;
         end
         if (ph == 16) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure_random();
         // receiver stalls while the sender keeps offering transactions
         if (ph == 16) hold_left = HOLD_CYCLES;
         n = $urandom_range(85, 30);
         repeat (n) issue_random();
         settle();
      end

      // frame longer than the store
      configure($urandom_range(40), $urandom_range(256), 1, 3, (1 << FRAME_BITS) - 1);
      repeat (40) issue_random();
      settle();

      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("running_average_background_subtraction regression: pass");
      else
         $display("running_average_background_subtraction regression: fail");
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/rabs_pkg.sv
src/rabs_if.sv
src/running_average_background_subtraction.sv
src/rabs_checker.sv
tb/sv/running_average_background_subtraction_test.sv
